>>> rtl/ecpr_pkg.sv
`default_nettype none

package ecpr_pkg;

   localparam int DEF_MAX_PAGES  = 64;
   localparam int DEF_MAX_FRAMES = 16;

   localparam int PAGE_W      = 7;
   localparam int FCNT_W      = 5;
   localparam int FRAME_OUT_W = 4;
   localparam int FAULT_W     = 32;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COUNT = 2'd1;

   localparam logic [PAGE_W-1:0] PAGE_COUNT_RESET  = 7'd64;
   localparam logic [FCNT_W-1:0] FRAME_COUNT_RESET = 5'd16;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 48;

   localparam int RSP_FAULT_LSB   = 0;
   localparam int RSP_FRAME_LSB   = 1;
   localparam int RSP_EVICTED_LSB = 5;
   localparam int RSP_VICTIM_LSB  = 6;
   localparam int RSP_TOTAL_LSB   = 13;
   localparam int RSP_USED_W      = 45;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_SWEEP_RD,
      ST_SWEEP_EV,
      ST_EVICT,
      ST_LOAD,
      ST_FINISH
   } ecpr_state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic read_req;
      logic decide;
      logic read_pos;
      logic evaluate;
      logic evict;
      logic load;
      logic publish;
   } ecpr_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic req_bad;
      logic hit;
      logic frame_free;
      logic found;
      logic sweep_end;
      logic rsp_room;
   } ecpr_status_type;

endpackage

`default_nettype wire

>>> rtl/ecpr_ram.sv
`default_nettype none

module ecpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/ecpr_ctrl.sv
`default_nettype none

module ecpr_ctrl
   import ecpr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire ecpr_status_type status,
   output ecpr_cmd_type         cmd
);

   ecpr_state_type state_ff;
   ecpr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = status.req_bad ? ST_FINISH : ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = (status.hit || status.frame_free) ? ST_FINISH : ST_SWEEP_RD;
         end
         ST_SWEEP_RD: begin
            state_in = ST_SWEEP_EV;
         end
         ST_SWEEP_EV: begin
            priority if (status.found) state_in = ST_EVICT;
            else if (status.sweep_end) state_in = ST_FINISH;
            else state_in = ST_SWEEP_RD;
         end
         ST_EVICT: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_room) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:    cmd.clear = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_LOOKUP:   cmd.read_req = 1'b1;
         ST_DECIDE:   cmd.decide = 1'b1;
         ST_SWEEP_RD: cmd.read_pos = 1'b1;
         ST_SWEEP_EV: cmd.evaluate = 1'b1;
         ST_EVICT:    cmd.evict = 1'b1;
         ST_LOAD:     cmd.load = 1'b1;
         ST_FINISH:   cmd.publish = status.rsp_room;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/ecpr_dp.sv
`default_nettype none

module ecpr_dp
   import ecpr_pkg::*;
#(
   parameter int MAX_PAGES  = DEF_MAX_PAGES,
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [PAGE_W-1:0]      req_page,
   input  wire logic                   req_is_write,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [RSP_TDATA_W-1:0]      rsp_data,
   output logic                        rsp_bad,
   input  wire ecpr_cmd_type           cmd,
   output ecpr_status_type             status
);

   localparam int IDX_W   = $clog2(MAX_PAGES);
   localparam int PC_W    = $clog2(MAX_PAGES + 1);
   localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FU_W    = $clog2(MAX_FRAMES + 1);
   localparam int STEP_W  = $clog2(2 * MAX_PAGES + 2);
   localparam int ENT_W   = FRAME_W + 3;
   localparam int V_BIT   = FRAME_W + 2;
   localparam int R_BIT   = FRAME_W + 1;
   localparam int W_BIT   = FRAME_W;

   logic [PAGE_W-1:0]      page_count_ff, page_count_in;
   logic [FCNT_W-1:0]      frame_count_ff, frame_count_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   wr_ff, wr_in;
   logic [FU_W-1:0]        frames_used_ff, frames_used_in;
   logic [IDX_W-1:0]       hand_ff, hand_in;
   logic [FAULT_W-1:0]     fault_count_ff, fault_count_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   phase_ff, phase_in;
   logic [IDX_W-1:0]       victim_ff, victim_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   logic                   res_fault_ff, res_fault_in;
   logic [FRAME_W-1:0]     res_frame_ff, res_frame_in;
   logic                   res_evicted_ff, res_evicted_in;
   logic [PAGE_W-1:0]      res_victim_ff, res_victim_in;
   logic                   res_bad_ff, res_bad_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_bad_ff, rsp_bad_in;

   logic [PC_W-1:0]   eff_pages;
   logic [FU_W-1:0]   eff_frames;
   logic [IDX_W-1:0]  req_idx;
   logic              req_bad;
   logic [IDX_W-1:0]  start;
   logic [IDX_W-1:0]  next_pos;
   logic [STEP_W-1:0] limit;
   logic              last_step;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENT_W-1:0]   ram_wdata;
   logic               ram_re;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENT_W-1:0]   ram_rdata;
   logic               ent_valid;
   logic               ent_ref;
   logic               ent_wr;
   logic [FRAME_W-1:0] ent_frame;
   logic               found;

   ecpr_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_PAGES)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ent_valid = ram_rdata[V_BIT];
   assign ent_ref   = ram_rdata[R_BIT];
   assign ent_wr    = ram_rdata[W_BIT];
   assign ent_frame = ram_rdata[FRAME_W-1:0];
   assign found     = ent_valid && !ent_ref && !ent_wr;

   always_comb begin
      if (page_count_ff == '0) begin
         eff_pages = PC_W'(1);
      end else if (32'(page_count_ff) > MAX_PAGES) begin
         eff_pages = PC_W'(MAX_PAGES);
      end else begin
         eff_pages = PC_W'(page_count_ff);
      end
      if (frame_count_ff == '0) begin
         eff_frames = FU_W'(1);
      end else if (32'(frame_count_ff) > MAX_FRAMES) begin
         eff_frames = FU_W'(MAX_FRAMES);
      end else begin
         eff_frames = FU_W'(frame_count_ff);
      end
   end

   assign req_idx   = IDX_W'(32'(req_page) - 32'd1);
   assign req_bad   = (req_page == '0) || (32'(req_page) > 32'(eff_pages));
   assign start     = (32'(hand_ff) < 32'(eff_pages)) ? hand_ff : '0;
   assign next_pos  = (32'(pos_ff) + 32'd1 == 32'(eff_pages)) ? '0
                                                              : IDX_W'(32'(pos_ff) + 32'd1);
   assign limit     = phase_ff ? STEP_W'(32'(eff_pages) * 2 + 1) : STEP_W'(eff_pages);
   assign last_step = (32'(step_ff) + 32'd1 == 32'(limit));

   assign status.clear_done = (32'(clr_ff) == MAX_PAGES - 1);
   assign status.req_bad    = req_bad;
   assign status.hit        = ent_valid;
   assign status.frame_free = 32'(frames_used_ff) < 32'(eff_frames);
   assign status.found      = found;
   assign status.sweep_end  = !found && phase_ff && last_step;
   assign status.rsp_room   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      page_count_in  = page_count_ff;
      frame_count_in = frame_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PAGE_COUNT:  page_count_in = csr_wdata[PAGE_W-1:0];
            CSR_FRAME_COUNT: frame_count_in = csr_wdata[FCNT_W-1:0];
            default: begin
               page_count_in = page_count_ff;
            end
         endcase
      end
   end

   always_comb begin
      idx_in         = idx_ff;
      wr_in          = wr_ff;
      frames_used_in = frames_used_ff;
      hand_in        = hand_ff;
      fault_count_in = fault_count_ff;
      pos_in         = pos_ff;
      step_in        = step_ff;
      phase_in       = phase_ff;
      victim_in      = victim_ff;
      clr_in         = clr_ff;
      res_fault_in   = res_fault_ff;
      res_frame_in   = res_frame_ff;
      res_evicted_in = res_evicted_ff;
      res_victim_in  = res_victim_ff;
      res_bad_in     = res_bad_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff;
      ram_wdata      = '0;
      ram_re         = 1'b0;
      ram_raddr      = idx_ff;

      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
         clr_in    = IDX_W'(32'(clr_ff) + 32'd1);
      end

      if (cmd.accept) begin
         idx_in         = req_idx;
         wr_in          = req_is_write;
         res_fault_in   = 1'b0;
         res_frame_in   = '0;
         res_evicted_in = 1'b0;
         res_victim_in  = '0;
         res_bad_in     = req_bad;
      end

      if (cmd.read_req) begin
         ram_re    = 1'b1;
         ram_raddr = idx_ff;
      end

      if (cmd.decide) begin
         if (ent_valid) begin
            ram_we       = 1'b1;
            ram_wdata    = {1'b1, 1'b1, ent_wr | wr_ff, ent_frame};
            res_frame_in = ent_frame;
         end else begin
            res_fault_in = 1'b1;
            if (fault_count_ff != '1) begin
               fault_count_in = fault_count_ff + 1'b1;
            end
            if (status.frame_free) begin
               ram_we         = 1'b1;
               ram_wdata      = {1'b1, 1'b1, wr_ff, FRAME_W'(frames_used_ff)};
               res_frame_in   = FRAME_W'(frames_used_ff);
               frames_used_in = FU_W'(32'(frames_used_ff) + 32'd1);
            end else begin
               pos_in   = start;
               step_in  = '0;
               phase_in = 1'b0;
            end
         end
      end

      if (cmd.read_pos) begin
         ram_re    = 1'b1;
         ram_raddr = pos_ff;
      end

      if (cmd.evaluate) begin
         if (found) begin
            victim_in      = pos_ff;
            res_frame_in   = ent_frame;
            res_evicted_in = 1'b1;
            res_victim_in  = PAGE_W'(32'(pos_ff) + 32'd1);
            hand_in        = next_pos;
         end else begin
            if (ent_valid) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff;
               if (phase_ff) begin
                  ram_wdata = {1'b1, ent_ref, 1'b0, ent_frame};
               end else begin
                  ram_wdata = {1'b1, 1'b0, ent_wr, ent_frame};
               end
            end
            if (last_step && !phase_ff) begin
               phase_in = 1'b1;
               step_in  = '0;
               pos_in   = start;
            end else begin
               step_in = STEP_W'(32'(step_ff) + 32'd1);
               pos_in  = next_pos;
            end
         end
      end

      if (cmd.evict) begin
         ram_we    = 1'b1;
         ram_waddr = victim_ff;
         ram_wdata = '0;
      end

      if (cmd.load) begin
         ram_we    = 1'b1;
         ram_waddr = idx_ff;
         ram_wdata = {1'b1, 1'b1, wr_ff, res_frame_ff};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_TDATA_W'({fault_count_ff, res_victim_ff, res_evicted_ff,
                                      FRAME_OUT_W'(res_frame_ff), res_fault_ff});
         rsp_bad_in   = res_bad_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff  <= PAGE_COUNT_RESET;
         frame_count_ff <= FRAME_COUNT_RESET;
         frames_used_ff <= '0;
         hand_ff        <= '0;
         fault_count_ff <= '0;
         clr_ff         <= '0;
         phase_ff       <= 1'b0;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         page_count_ff  <= page_count_in;
         frame_count_ff <= frame_count_in;
         frames_used_ff <= frames_used_in;
         hand_ff        <= hand_in;
         fault_count_ff <= fault_count_in;
         clr_ff         <= clr_in;
         phase_ff       <= phase_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      wr_ff          <= wr_in;
      pos_ff         <= pos_in;
      victim_ff      <= victim_in;
      res_fault_ff   <= res_fault_in;
      res_frame_ff   <= res_frame_in;
      res_evicted_ff <= res_evicted_in;
      res_victim_ff  <= res_victim_in;
      res_bad_ff     <= res_bad_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_bad_ff     <= rsp_bad_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_bad   = rsp_bad_ff;

endmodule

`default_nettype wire

>>> rtl/enhanced_clock_page_replacer_core.sv
`default_nettype none

// Channel   Direction  Word contents
// req       in         tdata: page [6:0], zero [7]; tuser: is_write
// rsp       out        tdata: fault, frame, evicted, victim_page, fault_total; tuser: bad_page
// csr       in         csr_index selects page_count (0) or frame_count (1), csr_wdata
//
// A hit or a miss into a free frame goes from idle via lookup and decide to finish, a bad
// page straight to finish; finish publishes the result into the output register once it has
// room, and idle can take the next word in the cycle after. A replacement reads and evaluates
// each page position the clock hand visits, up to p + (2 * p + 1) positions with p the
// page_count held to 1..MAX_PAGES, and if it finds a victim retires it and loads the page.
// After reset a clearing pass writes every page map entry before the first word is accepted.
// A finished result waits in an output register; a following word is accepted meanwhile.

module enhanced_clock_page_replacer_core
   import ecpr_pkg::*;
#(
   parameter int MAX_PAGES  = DEF_MAX_PAGES,
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // page [6:0], zero [7]
   input  wire logic                   req_tuser,  // is_write
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // fault, frame, evicted, victim_page,
                                                   // fault_total, zero
   output logic                        rsp_tuser,  // bad_page
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   ecpr_cmd_type    cmd;
   ecpr_status_type status;

   assign csr_ready = 1'b1;

   ecpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ecpr_dp #(
      .MAX_PAGES  (MAX_PAGES),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_page     (req_tdata[PAGE_W-1:0]),
      .req_is_write (req_tuser),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_data     (rsp_tdata),
      .rsp_bad      (rsp_tuser),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

`default_nettype wire
